### rtl/brt_pkg.sv
// Shared types, codes and default sizes for the bucketed record table.
// Used by every module of the block; depends on nothing.
package brt_pkg;

  // Default table geometry.
  localparam int BUCKETS_DEF = 32;
  localparam int WAYS_DEF    = 16;

  // Fixed field widths.
  localparam int HASH_W  = 32;
  localparam int WORD_W  = 32;
  localparam int CNT_W   = 10;

  // Operation codes.
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;
  localparam logic [1:0] MODE_DELETE = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  // One stored record.
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [WORD_W-1:0] rank;
    logic [WORD_W-1:0] data_loc;
    logic [WORD_W-1:0] meta_loc;
  } record_t;

endpackage

### rtl/brt_rem.sv
// Bucket select unit: hash modulo BUCKETS, taken from the low hash bits.
// Depends on brt_pkg.
module brt_rem #(
  parameter int BUCKETS = brt_pkg::BUCKETS_DEF,
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [brt_pkg::HASH_W-1:0] value,
  output logic                      done,
  output logic [BW-1:0]             rem
);

  logic          done_r;
  logic [BW-1:0] rem_r;

  // The result is ready in the cycle after start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  // The bucket count is a power of two, so the remainder is the low hash bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= value[BW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### rtl/brt_mem.sv
// Record store: one write port and one registered read port.
// Depends on brt_pkg for the record type.
module brt_mem #(
  parameter int DEPTH = brt_pkg::BUCKETS_DEF * brt_pkg::WAYS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output brt_pkg::record_t rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  brt_pkg::record_t wr_data
);

  brt_pkg::record_t mem [DEPTH];
  brt_pkg::record_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/bucketed_record_table_evict_unit.sv
// Top level of the bucketed record table with max-rank eviction.
// Depends on brt_pkg, brt_rem and brt_mem.
//
//  channel  handshake            payload
//  -------  -------------------  ---------------------------------------------
//  input    start & !busy        in_mode, in_key_hash, in_rank_in,
//                                in_data_location_in, in_meta_location_in
//  result   out_strobe (1 cycle) out_status, out_valid, out_hash, out_rank,
//                                out_data_location, out_meta_location,
//                                out_entry_total
//
// A zero hash goes from acceptance straight to the final step. Any other item
// passes bucket select, fill read, fill check, a scan over the single store
// read port if needed, and the final step. Update, find and delete scan down
// from the last filled slot until a match (none on an empty bucket); an add
// scans every slot of a full bucket and none with room. The next item can be
// taken while the result is shown. BUCKETS must be a power of two.
// Reset clears the sequencer, the bucket fill valid bits and the count.
// The result is shown for one cycle and cannot be stalled.
module bucketed_record_table_evict_unit #(
  parameter int BUCKETS = brt_pkg::BUCKETS_DEF,
  parameter int WAYS    = brt_pkg::WAYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_mode,
  input  logic [brt_pkg::HASH_W-1:0]    in_key_hash,
  input  logic [brt_pkg::WORD_W-1:0]    in_rank_in,
  input  logic [brt_pkg::WORD_W-1:0]    in_data_location_in,
  input  logic [brt_pkg::WORD_W-1:0]    in_meta_location_in,
  output logic                          out_strobe,
  output logic [1:0]                    out_status,
  output logic                          out_valid,
  output logic [brt_pkg::HASH_W-1:0]    out_hash,
  output logic [brt_pkg::WORD_W-1:0]    out_rank,
  output logic [brt_pkg::WORD_W-1:0]    out_data_location,
  output logic [brt_pkg::WORD_W-1:0]    out_meta_location,
  output logic [brt_pkg::CNT_W-1:0]     out_entry_total
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int SW    = $clog2(WAYS);
  localparam int FW    = $clog2(WAYS + 1);
  localparam int DEPTH = BUCKETS * WAYS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_FRD  = 3'd2;
  localparam logic [2:0] S_FCHK = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Latched item.
  logic [1:0]                 mode_r;
  logic                       zero_r;
  brt_pkg::record_t           in_rec_r;

  // Bucket and fill.
  logic [BW-1:0]              bkt_r;
  logic [FW-1:0]              fill_mem [BUCKETS];
  logic [BUCKETS-1:0]         fill_vld_r;
  logic [FW-1:0]              fill_q_r;
  logic                       fill_v_q_r;
  logic [FW-1:0]              fill_cur;
  logic [FW-1:0]              fill_dec;
  logic [FW-1:0]              fill_r;
  logic                       app_r;

  // Scan state.
  logic [SW-1:0]              iss_idx_r;
  logic [FW-1:0]              iss_left_r;
  logic                       pipe_vld_r;
  logic [SW-1:0]              pipe_idx_r;
  logic                       first_r;
  logic                       hit_r;
  logic [SW-1:0]              hit_idx_r;
  brt_pkg::record_t           best_r;
  logic [SW-1:0]              best_idx_r;
  brt_pkg::record_t           last_r;

  logic [brt_pkg::CNT_W-1:0]  count_r;
  logic [brt_pkg::CNT_W-1:0]  count_nxt;

  // Output registers.
  logic                       out_strobe_r;
  logic [1:0]                 out_status_r;
  logic                       out_valid_r;
  brt_pkg::record_t           out_rec_r;
  logic [brt_pkg::CNT_W-1:0]  out_total_r;

  // Remainder unit and record store hookup.
  logic                       rem_start;
  logic                       rem_done;
  logic [BW-1:0]              rem;
  logic                       iss_go;
  logic                       match;
  logic                       rank_gt;
  logic                       scan_end;
  logic [AW-1:0]              base;
  logic [AW-1:0]              rd_addr;
  brt_pkg::record_t           rd_data;
  logic                       wr_en;
  logic [SW-1:0]              wr_slot;
  brt_pkg::record_t           wr_data;

  assign busy      = (state_r != S_IDLE);
  assign rem_start = (state_r == S_IDLE) && start && (in_key_hash != '0);

  brt_rem #(.BUCKETS(BUCKETS)) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .value (in_key_hash),
    .done  (rem_done),
    .rem   (rem)
  );

  assign base    = AW'(bkt_r) * AW'(WAYS);
  assign iss_go  = (state_r == S_SCAN) && (iss_left_r != '0);
  assign rd_addr = base + AW'(iss_idx_r);

  brt_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .rd_en   (iss_go),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (base + AW'(wr_slot)),
    .wr_data (wr_data)
  );

  // Shared compare unit on the record just read.
  assign match    = (rd_data.hash == in_rec_r.hash);
  assign rank_gt  = (rd_data.rank > best_r.rank);
  assign scan_end = pipe_vld_r &&
                    ((iss_left_r == '0) || ((mode_r != brt_pkg::MODE_ADD) && match));

  assign fill_cur = fill_v_q_r ? fill_q_r : '0;
  assign fill_dec = fill_cur - FW'(1);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = (in_key_hash == '0) ? S_FIN : S_MOD;
        end
      end
      S_MOD: begin
        if (rem_done) begin
          state_nxt = S_FRD;
        end
      end
      S_FRD:  state_nxt = S_FCHK;
      S_FCHK: begin
        if (mode_r == brt_pkg::MODE_ADD) begin
          state_nxt = (fill_cur < FW'(WAYS)) ? S_FIN : S_SCAN;
        end else begin
          state_nxt = (fill_cur == '0) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Record write in the final step.
  always_comb begin
    wr_en   = 1'b0;
    wr_slot = hit_idx_r;
    wr_data = in_rec_r;
    if ((state_r == S_FIN) && !zero_r) begin
      case (mode_r)
        brt_pkg::MODE_ADD: begin
          wr_en   = 1'b1;
          wr_slot = app_r ? fill_r[SW-1:0] : best_idx_r;
        end
        brt_pkg::MODE_UPDATE: wr_en = hit_r;
        brt_pkg::MODE_DELETE: begin
          wr_en   = hit_r;
          wr_data = last_r;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  // Record count after the operation.
  always_comb begin
    count_nxt = count_r;
    if (!zero_r) begin
      if ((mode_r == brt_pkg::MODE_ADD) && app_r) begin
        count_nxt = count_r + 1'b1;
      end else if ((mode_r == brt_pkg::MODE_DELETE) && hit_r) begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_vld_r   <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
      pipe_vld_r   <= 1'b0;
      iss_left_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_FIN);
      pipe_vld_r   <= iss_go;
      if (state_r == S_FCHK) begin
        iss_left_r <= (mode_r == brt_pkg::MODE_ADD) ? FW'(WAYS) : fill_cur;
      end else if (iss_go) begin
        iss_left_r <= iss_left_r - 1'b1;
      end
      if ((state_r == S_FIN) && !zero_r) begin
        count_r <= count_nxt;
        if ((mode_r == brt_pkg::MODE_ADD) && app_r) begin
          fill_vld_r[bkt_r] <= 1'b1;
        end
      end
    end
  end

  // Bucket fill store, read in the cycle after the bucket is known.
  always_ff @(posedge clk) begin
    if (state_r == S_FRD) begin
      fill_q_r   <= fill_mem[bkt_r];
      fill_v_q_r <= fill_vld_r[bkt_r];
    end
    if ((state_r == S_FIN) && !zero_r) begin
      if ((mode_r == brt_pkg::MODE_ADD) && app_r) begin
        fill_mem[bkt_r] <= fill_r + 1'b1;
      end else if ((mode_r == brt_pkg::MODE_DELETE) && hit_r) begin
        fill_mem[bkt_r] <= fill_r - 1'b1;
      end
    end
  end

  // Item latch, scan datapath and result registers.
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && start) begin
      mode_r   <= in_mode;
      zero_r   <= (in_key_hash == '0);
      in_rec_r <= '{hash: in_key_hash, rank: in_rank_in,
                    data_loc: in_data_location_in, meta_loc: in_meta_location_in};
    end
    if (rem_done) begin
      bkt_r <= rem;
    end
    if (state_r == S_FCHK) begin
      fill_r    <= fill_cur;
      app_r     <= fill_cur < FW'(WAYS);
      iss_idx_r <= (mode_r == brt_pkg::MODE_ADD) ? '0 : fill_dec[SW-1:0];
      first_r   <= 1'b1;
      hit_r     <= 1'b0;
    end
    if (iss_go) begin
      iss_idx_r  <= (iss_idx_r == '0) ? SW'(WAYS - 1) : iss_idx_r - 1'b1;
      pipe_idx_r <= iss_idx_r;
    end
    // Compare the record that came back from the store.
    if ((state_r == S_SCAN) && pipe_vld_r) begin
      first_r <= 1'b0;
      if (mode_r == brt_pkg::MODE_ADD) begin
        if (first_r || rank_gt) begin
          best_r     <= rd_data;
          best_idx_r <= pipe_idx_r;
        end
      end else begin
        if (first_r) begin
          last_r <= rd_data;
        end
        if (match) begin
          hit_r     <= 1'b1;
          hit_idx_r <= pipe_idx_r;
          best_r    <= rd_data;
        end
      end
    end
    // Build the result.
    if (state_r == S_FIN) begin
      out_total_r  <= zero_r ? count_r : count_nxt;
      out_status_r <= brt_pkg::ST_OK;
      out_valid_r  <= 1'b0;
      out_rec_r    <= '0;
      if (zero_r) begin
        out_status_r <= brt_pkg::ST_ZERO;
      end else if (mode_r == brt_pkg::MODE_ADD) begin
        if (!app_r) begin
          out_valid_r <= 1'b1;
          out_rec_r   <= best_r;
        end
      end else if (!hit_r) begin
        out_status_r <= brt_pkg::ST_MISS;
      end else if (mode_r == brt_pkg::MODE_FIND) begin
        out_valid_r <= 1'b1;
        out_rec_r   <= best_r;
      end
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_valid         = out_valid_r;
  assign out_hash          = out_rec_r.hash;
  assign out_rank          = out_rec_r.rank;
  assign out_data_location = out_rec_r.data_loc;
  assign out_meta_location = out_rec_r.meta_loc;
  assign out_entry_total   = out_total_r;

`ifndef NO_ASSERTIONS
  // Results never come in consecutive cycles.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("two results in consecutive cycles");

  // A zero hash is answered from the final step, with no bucket select or scan.
  a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_key_hash == '0)) |-> ##2 out_strobe_r)
    else $error("zero hash not answered in time");

  // A record is returned only with an ok status.
  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_valid_r) |-> (out_status_r == brt_pkg::ST_OK))
    else $error("record returned with error status");

  // The scan never issues more reads than a bucket holds.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (iss_left_r <= FW'(WAYS)))
    else $error("scan count out of range");
`endif

endmodule

### tb/tb_bucketed_record_table_evict_unit.sv
// Self-checking testbench for the bucketed record table with max-rank eviction.
// Depends on brt_pkg and the bucketed_record_table_evict_unit RTL.
// A behavioral table model predicts every result; a monitor compares them in order.
`timescale 1ns / 100ps

module tb_bucketed_record_table_evict_unit;

  localparam int NB = 32;
  localparam int NW = 16;
  localparam int CYCLE_LIMIT = 400000;

  // Expected answer of one operation.
  typedef struct {
    logic [1:0]  status;
    logic        valid;
    logic [31:0] hash;
    logic [31:0] rank;
    logic [31:0] dloc;
    logic [31:0] mloc;
    logic [9:0]  total;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = brt_pkg::MODE_ADD;
  logic [31:0] in_key_hash = '0;
  logic [31:0] in_rank_in = '0;
  logic [31:0] in_data_location_in = '0;
  logic [31:0] in_meta_location_in = '0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic        out_valid;
  logic [31:0] out_hash;
  logic [31:0] out_rank;
  logic [31:0] out_data_location;
  logic [31:0] out_meta_location;
  logic [9:0]  out_entry_total;

  // Shadow copy of the table.
  brt_pkg::record_t shadow_rec [NB][NW];
  int unsigned      shadow_fill [NB];
  int unsigned      shadow_count;
  int unsigned      key_pool [$];

  answer_t pending_answers [$];
  int      error_count = 0;
  int      cycle_count = 0;
  bit      idle_on = 1'b1;

  bucketed_record_table_evict_unit DUT (.*);

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Apply one operation to the shadow table and return its answer.
  function automatic answer_t predict_table_op(logic [1:0] op, logic [31:0] h,
                                               logic [31:0] r, logic [31:0] d,
                                               logic [31:0] m);
    answer_t a;
    int b;
    int k;
    int best;
    int last;
    a = '{brt_pkg::ST_OK, 1'b0, '0, '0, '0, '0, '0};
    if (h == 0) begin
      a.status = brt_pkg::ST_ZERO;
    end else begin
      b = h % NB;
      if (op == brt_pkg::MODE_ADD) begin
        if (shadow_fill[b] < NW) begin
          shadow_rec[b][shadow_fill[b]] = '{h, r, d, m};
          shadow_fill[b]++;
          shadow_count++;
        end else begin
          best = 0;
          for (int i = NW - 1; i > 0; i--)
            if (shadow_rec[b][i].rank > shadow_rec[b][best].rank) best = i;
          a.valid = 1'b1;
          a.hash = shadow_rec[b][best].hash;
          a.rank = shadow_rec[b][best].rank;
          a.dloc = shadow_rec[b][best].data_loc;
          a.mloc = shadow_rec[b][best].meta_loc;
          shadow_rec[b][best] = '{h, r, d, m};
        end
      end else begin
        k = -1;
        for (int i = int'(shadow_fill[b]) - 1; i >= 0; i--)
          if (k < 0 && shadow_rec[b][i].hash == h) k = i;
        if (k < 0) begin
          a.status = brt_pkg::ST_MISS;
        end else if (op == brt_pkg::MODE_UPDATE) begin
          shadow_rec[b][k] = '{h, r, d, m};
        end else if (op == brt_pkg::MODE_FIND) begin
          a.valid = 1'b1;
          a.hash = shadow_rec[b][k].hash;
          a.rank = shadow_rec[b][k].rank;
          a.dloc = shadow_rec[b][k].data_loc;
          a.mloc = shadow_rec[b][k].meta_loc;
        end else begin
          last = shadow_fill[b] - 1;
          shadow_rec[b][k] = shadow_rec[b][last];
          shadow_fill[b] = last;
          shadow_count--;
        end
      end
    end
    a.total = shadow_count[9:0];
    return a;
  endfunction

  // Random idle burst before an item; start drops for its length.
  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Send one item and record its expected answer when it is accepted.
  // Start stays high after acceptance so the next item can follow at once.
  task automatic send_item(logic [1:0] op, logic [31:0] h, logic [31:0] r,
                           logic [31:0] d, logic [31:0] m);
    idle_gap();
    start <= 1'b1;
    in_mode <= op;
    in_key_hash <= h;
    in_rank_in <= r;
    in_data_location_in <= d;
    in_meta_location_in <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.push_back(predict_table_op(op, h, r, d, m));
    if (op == brt_pkg::MODE_ADD && h != 0) key_pool.push_back(h);
  endtask

  // Compare each result with the oldest expected answer.
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_strobe) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, status %0d hash %h", $time, out_status,
                 out_hash);
        error_count++;
      end else begin
        e = pending_answers.pop_front();
        if (out_status !== e.status || out_valid !== e.valid ||
            out_hash !== e.hash || out_rank !== e.rank ||
            out_data_location !== e.dloc || out_meta_location !== e.mloc ||
            out_entry_total !== e.total) begin
          $display("%0t: mismatch expected st=%0d v=%0b h=%h r=%h d=%h m=%h n=%0d",
                   $time, e.status, e.valid, e.hash, e.rank, e.dloc, e.mloc, e.total);
          $display("%0t:          actual   st=%0d v=%0b h=%h r=%h d=%h m=%h n=%0d",
                   $time, out_status, out_valid, out_hash, out_rank,
                   out_data_location, out_meta_location, out_entry_total);
          error_count++;
        end
      end
    end
  end

  // Pick a key: mostly one already added, otherwise a random one.
  function automatic logic [31:0] pick_key();
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return $urandom();
  endfunction

  // Directed extremes: zero hash, every mode, misses, duplicates, full bucket.
  task automatic test_directed();
    send_item(brt_pkg::MODE_ADD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(brt_pkg::MODE_FIND, 32'h0, '0, '0, '0);
    send_item(brt_pkg::MODE_FIND, 32'h0000_0021, '0, '0, '0);
    send_item(brt_pkg::MODE_UPDATE, 32'h0000_0021, 32'h5, '0, '0);
    send_item(brt_pkg::MODE_DELETE, 32'h0000_0021, '0, '0, '0);
    send_item(brt_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_item(brt_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    send_item(brt_pkg::MODE_FIND, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(brt_pkg::MODE_UPDATE, 32'hFFFF_FFFF, 32'h1234, 32'hAAAA_5555,
              32'h5555_AAAA);
    send_item(brt_pkg::MODE_FIND, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(brt_pkg::MODE_DELETE, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(brt_pkg::MODE_FIND, 32'hFFFF_FFFF, '0, '0, '0);
    // Fill bucket 1 with equal ranks, then overflow it to evict slot zero.
    for (int i = 0; i < NW + 1; i++)
      send_item(brt_pkg::MODE_ADD, 32'h1 + 32'(i) * NB, 32'h77, 32'(i), ~32'(i));
  endtask

  // Random mix aimed at a few hot buckets so they fill and evict.
  task automatic test_random(int count);
    logic [31:0] h;
    for (int n = 0; n < count; n++) begin
      if (n > count - 150) idle_on = 1'b0;
      h = $urandom_range(0, 1) ? pick_key()
                               : {$urandom_range(0, 63) == 0 ? 27'h0 : 27'($urandom()),
                                  5'($urandom_range(0, 3))};
      send_item(2'($urandom_range(0, 3)), $urandom_range(0, 40) == 0 ? 32'h0 : h,
                $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom(),
                $urandom(), $urandom());
    end
  endtask

  initial begin
    for (int b = 0; b < NB; b++) shadow_fill[b] = 0;
    shadow_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1420);
    start <= 1'b0;
    while (pending_answers.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
